[hdl/strint_pkg.sv]
// Shared types and constants for the string-to-integer parser.
package strint_pkg;

	localparam int CountWidth    = 16;
	localparam int ConsumedWidth = 16;
	localparam int ValueWidth    = 64;
	localparam int RadixWidth    = 5;
	localparam int CharWidth     = 8;

	localparam logic [CharWidth-1:0] ChSpace = 8'h20;
	localparam logic [CharWidth-1:0] ChTab   = 8'h09;
	localparam logic [CharWidth-1:0] ChLf    = 8'h0A;
	localparam logic [CharWidth-1:0] ChVt    = 8'h0B;
	localparam logic [CharWidth-1:0] ChFf    = 8'h0C;
	localparam logic [CharWidth-1:0] ChCr    = 8'h0D;
	localparam logic [CharWidth-1:0] ChPlus  = 8'h2B;
	localparam logic [CharWidth-1:0] ChMinus = 8'h2D;
	localparam logic [CharWidth-1:0] ChZero  = 8'h30;
	localparam logic [CharWidth-1:0] ChNine  = 8'h39;
	localparam logic [CharWidth-1:0] ChUpA   = 8'h41;
	localparam logic [CharWidth-1:0] ChUpF   = 8'h46;
	localparam logic [CharWidth-1:0] ChUpX   = 8'h58;
	localparam logic [CharWidth-1:0] ChLoA   = 8'h61;
	localparam logic [CharWidth-1:0] ChLoF   = 8'h66;
	localparam logic [CharWidth-1:0] ChLoX   = 8'h78;

	localparam logic [RadixWidth-1:0] BaseOct = 5'd8;
	localparam logic [RadixWidth-1:0] BaseDec = 5'd10;
	localparam logic [RadixWidth-1:0] BaseHex = 5'd16;

	typedef struct packed {
		logic signed [ValueWidth-1:0] value;
		logic [ConsumedWidth-1:0]     consumed;
	} result_t;

	typedef struct packed {
		logic [CharWidth-1:0] char_code;
		logic                 start_req;
	} word_t;

	function automatic logic [ConsumedWidth-1:0] sat_consumed(
		input logic [CountWidth-1:0] cnt
	);
		logic [ConsumedWidth-1:0] r;
		if (CountWidth > ConsumedWidth && cnt > CountWidth'(65535)) begin
			r = '1;
		end else begin
			r = ConsumedWidth'(cnt);
		end
		return r;
	endfunction

endpackage

[hdl/strint_parse.sv]
// Parse state and per-character next-state logic.
module strint_parse
	import strint_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  word_t                 word,
	input  logic [RadixWidth-1:0] radix,
	output logic                  emit,
	output result_t               res
);

	typedef enum logic [2:0] {
		PH_WS,
		PH_SIGNED,
		PH_ZERO,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	phase_t                  phase_q, phase_d;
	logic [ValueWidth-1:0]   acc_q, acc_d;
	logic                    neg_q, neg_d;
	logic [RadixWidth-1:0]   base_q, base_d;
	logic [CountWidth-1:0]   cnt_q, cnt_d;

	logic                    handled;
	logic                    bump;
	logic                    dig_ok;
	logic [3:0]              dig;
	logic [CharWidth-1:0]    c;
	logic                    is_space;

	assign c = word.char_code;
	assign is_space = (c == ChSpace) || (c == ChTab) || (c == ChLf) ||
		(c == ChCr) || (c == ChFf) || (c == ChVt);

	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		neg_d   = neg_q;
		base_d  = base_q;
		cnt_d   = cnt_q;
		handled = 1'b0;
		bump    = 1'b0;
		emit    = 1'b0;
		dig     = '0;
		dig_ok  = 1'b0;
		if (word.start_req) begin
			phase_d = PH_WS;
			acc_d   = '0;
			neg_d   = 1'b0;
			base_d  = '0;
			cnt_d   = '0;
		end
		if (phase_d == PH_DONE) begin
			handled = 1'b1;
		end
		if (!handled && phase_d == PH_WS) begin
			if (is_space) begin
				bump    = 1'b1;
				handled = 1'b1;
			end else begin
				phase_d = PH_SIGNED;
				if (c == ChMinus || c == ChPlus) begin
					neg_d   = (c == ChMinus);
					bump    = 1'b1;
					handled = 1'b1;
				end
			end
		end
		if (!handled && phase_d == PH_SIGNED) begin
			if (radix == '0) begin
				if (c == ChZero) begin
					base_d  = BaseOct;
					phase_d = PH_ZERO;
					bump    = 1'b1;
					handled = 1'b1;
				end else begin
					base_d = BaseDec;
				end
			end else begin
				base_d = radix;
			end
			if (!handled) begin
				phase_d = PH_DIGITS;
			end
		end else if (!handled && phase_d == PH_ZERO) begin
			phase_d = PH_DIGITS;
			if (c == ChLoX || c == ChUpX) begin
				base_d  = BaseHex;
				bump    = 1'b1;
				handled = 1'b1;
			end
		end
		if (!handled) begin
			if (c >= ChZero && c <= ChNine) begin
				dig    = 4'(c - ChZero);
				dig_ok = 1'b1;
			end else if (base_d == BaseHex && c >= ChLoA && c <= ChLoF) begin
				dig    = 4'(c - ChLoA + 8'd10);
				dig_ok = 1'b1;
			end else if (base_d == BaseHex && c >= ChUpA && c <= ChUpF) begin
				dig    = 4'(c - ChUpA + 8'd10);
				dig_ok = 1'b1;
			end
			if (dig_ok && RadixWidth'(dig) >= base_d) begin
				dig_ok = 1'b0;
			end
			if (dig_ok) begin
				acc_d = acc_d * ValueWidth'(base_d) + ValueWidth'(dig);
				bump  = 1'b1;
			end else begin
				emit    = 1'b1;
				phase_d = PH_DONE;
			end
		end
		if (bump && cnt_d != '1) begin
			cnt_d = cnt_d + 1'b1;
		end
	end

	assign res.value    = neg_d ? ValueWidth'(0) - acc_d : acc_d;
	assign res.consumed = sat_consumed(cnt_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WS;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			base_q  <= '0;
			cnt_q   <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			base_q  <= base_d;
			cnt_q   <= cnt_d;
		end
	end

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE && !(en && word.start_req) |=> phase_q == PH_DONE)
		else $error("done phase left without a start");

	a_emit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		en && emit |=> phase_q == PH_DONE)
		else $error("result emitted without entering done phase");

	a_no_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE && !word.start_req |-> !emit)
		else $error("result emitted from done phase");

endmodule

[hdl/string_to_integer_parser_core.sv]
// Top level: input register, parse stage, output register and radix register.
//
//  channel | signals                            | accepted when
//  --------+------------------------------------+---------------------------
//  in      | in_valid, in_stall, char_code,     | in_valid && !in_stall
//          | start_req                          |
//  out     | out_valid, out_stall, value,       | out_valid && !out_stall
//          | consumed                           |
//  config  | radix_wr_en, radix_wr_data         | radix_wr_en
//
// One word per cycle sustained while out_stall is low; a result passes the input register, then the output register.
// The parse next-state logic (one 64x5 multiply-accumulate) is combinational.
// Reset clears the parse state to the whitespace phase and radix to zero.
// out_stall holds the output register; in_stall rises once the input
// register is also full.
module string_to_integer_parser_core
	import strint_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         radix_wr_en,
	input  logic [RadixWidth-1:0]        radix_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [CharWidth-1:0]         char_code,
	input  logic                         start_req,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [ValueWidth-1:0] value,
	output logic [ConsumedWidth-1:0]     consumed
);

	logic [RadixWidth-1:0] radix_q;
	logic                  valid_s1;
	word_t                 word_s1;
	logic                  valid_s2;
	result_t               res_s2;
	logic                  advance;
	logic                  step_en;
	logic                  emit;
	result_t               res;

	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign step_en  = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= '0;
		end else if (radix_wr_en) begin
			radix_q <= radix_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_s1.char_code <= char_code;
			word_s1.start_req <= start_req;
		end
	end

	strint_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (step_en),
		.word   (word_s1),
		.radix  (radix_q),
		.emit   (emit),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= step_en && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && emit) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign value     = res_s2.value;
	assign consumed  = res_s2.consumed;

	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && emit |=> valid_s2 && res_s2 == $past(res))
		else $error("emitted result not captured");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(word_s1))
		else $error("stalled input word lost");

	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !(step_en && emit) |=> !valid_s2)
		else $error("result without an emitting word");

endmodule

[dv/string_to_integer_parser_core_test.sv]
`timescale 1ns / 100ps
// Testbench for the parser core: directed and random strings checked by a predictor.
module string_to_integer_parser_core_test;
	import strint_pkg::*;

	typedef enum logic [2:0] {
		SCAN_BLANK,
		SCAN_SIGN,
		SCAN_ZERO,
		SCAN_DIGITS,
		SCAN_DONE
	} scan_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         radix_wr_en = 1'b0;
	logic [RadixWidth-1:0]        radix_wr_data = '0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [CharWidth-1:0]         char_code = '0;
	logic                         start_req = 1'b0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic signed [ValueWidth-1:0] value;
	logic [ConsumedWidth-1:0]     consumed;

	string_to_integer_parser_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.radix_wr_en  (radix_wr_en),
		.radix_wr_data(radix_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_code    (char_code),
		.start_req    (start_req),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.value        (value),
		.consumed     (consumed)
	);

	always #4 clk = ~clk;

	localparam logic [CharWidth-1:0] ChNul = 8'h00;
	localparam logic [CharWidth-1:0] ChDot = 8'h2E;

	logic [CharWidth-1:0] blank_chars [6] = '{ChSpace, ChTab, ChLf, ChVt, ChFf, ChCr};

	word_t   pending_chars[$];
	result_t due_integers[$];

	// parser state as predicted
	logic [RadixWidth-1:0]    cfg_radix = '0;
	scan_t                    scan_state = SCAN_BLANK;
	logic [ValueWidth-1:0]    magnitude = '0;
	logic                     minus_seen = 1'b0;
	logic [RadixWidth-1:0]    live_base = '0;
	logic [ConsumedWidth-1:0] char_tally = '0;

	bit in_taken = 1'b0;
	bit send_gapless = 1'b0;
	bit recv_gapless = 1'b0;
	bit squeeze_req = 1'b0;
	bit squeeze_done = 1'b0;
	int gap_left = 0;
	int hold_left = 0;
	int fail_count = 0;
	int ints_checked = 0;
	int chars_taken = 0;
	int radix_settings = 0;

	function automatic void bump_tally();
		if (char_tally != '1) begin
			char_tally = char_tally + 1'b1;
		end
	endfunction

	task automatic parse_char(input logic [CharWidth-1:0] c, input logic sr);
		int      dv;
		bit      is_digit;
		result_t r;
		if (sr) begin
			scan_state = SCAN_BLANK;
			magnitude = '0;
			minus_seen = 1'b0;
			live_base = '0;
			char_tally = '0;
		end
		if (scan_state == SCAN_DONE) begin
			return;
		end
		if (scan_state == SCAN_BLANK) begin
			if (c == ChSpace || c == ChTab || c == ChLf ||
				c == ChCr || c == ChFf || c == ChVt) begin
				bump_tally();
				return;
			end
			scan_state = SCAN_SIGN;
			if (c == ChMinus || c == ChPlus) begin
				minus_seen = (c == ChMinus);
				bump_tally();
				return;
			end
		end
		if (scan_state == SCAN_SIGN) begin
			if (cfg_radix == '0) begin
				if (c == ChZero) begin
					live_base = BaseOct;
					scan_state = SCAN_ZERO;
					bump_tally();
					return;
				end
				live_base = BaseDec;
			end else begin
				live_base = cfg_radix;
			end
			scan_state = SCAN_DIGITS;
		end else if (scan_state == SCAN_ZERO) begin
			scan_state = SCAN_DIGITS;
			if (c == ChLoX || c == ChUpX) begin
				live_base = BaseHex;
				bump_tally();
				return;
			end
		end
		is_digit = 1'b0;
		dv = 0;
		if (c >= ChZero && c <= ChNine) begin
			dv = c - ChZero;
			is_digit = 1'b1;
		end else if (live_base == BaseHex && c >= ChLoA && c <= ChLoF) begin
			dv = c - ChLoA + 10;
			is_digit = 1'b1;
		end else if (live_base == BaseHex && c >= ChUpA && c <= ChUpF) begin
			dv = c - ChUpA + 10;
			is_digit = 1'b1;
		end
		if (is_digit && dv < live_base) begin
			magnitude = magnitude * 64'(live_base) + 64'(dv);
			bump_tally();
			return;
		end
		r.value = minus_seen ? -magnitude : magnitude;
		r.consumed = char_tally;
		due_integers.push_back(r);
		scan_state = SCAN_DONE;
	endtask

	function automatic int pick_gap();
		int r;
		if (send_gapless) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end else if (r < 94) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	always @(negedge clk) begin : drive_chars
		word_t w;
		if (!in_valid || in_taken) begin
			if (gap_left > 0) begin
				gap_left = gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_chars.size() > 0) begin
				w = pending_chars.pop_front();
				char_code <= w.char_code;
				start_req <= w.start_req;
				in_valid <= 1'b1;
				gap_left = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : drive_stall
		int r;
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else if (squeeze_req && !squeeze_done) begin
			// hold off long enough for the core to back up
			hold_left = 120;
			squeeze_done = 1'b1;
			out_stall <= 1'b1;
		end else if (recv_gapless) begin
			out_stall <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				out_stall <= 1'b0;
			end else if (r < 96) begin
				hold_left = $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				hold_left = $urandom_range(8, 30);
				out_stall <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		in_taken = (in_valid === 1'b1) && (in_stall === 1'b0);
		if (in_taken) begin
			chars_taken++;
			parse_char(char_code, start_req);
		end
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			if (due_integers.size() == 0) begin
				$display("%0t: unexpected result: expected none, got value %0d consumed %0d",
					$time, value, consumed);
				fail_count++;
			end else begin
				want = due_integers.pop_front();
				ints_checked++;
				if (value !== want.value) begin
					$display("%0t: value mismatch: expected %0d, got %0d",
						$time, want.value, value);
					fail_count++;
				end
				if (consumed !== want.consumed) begin
					$display("%0t: consumed mismatch: expected %0d, got %0d",
						$time, want.consumed, consumed);
					fail_count++;
				end
			end
		end
	end

	task automatic put(input logic [CharWidth-1:0] c, input bit sr);
		word_t w;
		w.char_code = c;
		w.start_req = sr;
		pending_chars.push_back(w);
	endtask

	task automatic put_text(input string s, input bit sr);
		for (int i = 0; i < s.len(); i++) begin
			put(s[i], sr && i == 0);
		end
	endtask

	task automatic settle();
		do begin
			@(posedge clk);
		end while (pending_chars.size() != 0 || in_valid || due_integers.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_radix(input logic [RadixWidth-1:0] v);
		@(negedge clk);
		radix_wr_en <= 1'b1;
		radix_wr_data <= v;
		@(negedge clk);
		radix_wr_en <= 1'b0;
		cfg_radix = v;
		radix_settings++;
	endtask

	task automatic add_number(output int n);
		logic [CharWidth-1:0] text[$];
		int base;
		int ndig;
		int dmax;
		int d;
		int r;
		if ($urandom_range(0, 9) < 3) begin
			repeat ($urandom_range(1, 3)) text.push_back(blank_chars[$urandom_range(0, 5)]);
		end
		r = $urandom_range(0, 3);
		if (r == 0) begin
			text.push_back(ChMinus);
		end else if (r == 1) begin
			text.push_back(ChPlus);
		end
		base = cfg_radix;
		if (cfg_radix == '0) begin
			r = $urandom_range(0, 9);
			if (r < 3) begin
				text.push_back(ChZero);
				text.push_back($urandom_range(0, 1) ? ChLoX : ChUpX);
				base = 16;
			end else if (r < 6) begin
				text.push_back(ChZero);
				base = 8;
			end else begin
				base = 10;
			end
		end
		ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 24) : $urandom_range(0, 6);
		dmax = (base == 16) ? 15 : ((base > 10) ? 9 : base - 1);
		repeat (ndig) begin
			d = $urandom_range(0, dmax);
			if (d < 10) begin
				text.push_back(8'(ChZero + d));
			end else begin
				text.push_back(8'(($urandom_range(0, 1) ? ChLoA : ChUpA) + d - 10));
			end
		end
		case ($urandom_range(0, 4))
			0: text.push_back(ChNul);
			1: text.push_back(blank_chars[$urandom_range(0, 5)]);
			2: text.push_back(ChDot);
			default: text.push_back(8'($urandom_range(0, 255)));
		endcase
		n = text.size();
		foreach (text[i]) put(text[i], i == 0);
		// trailing chars after the stop
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)), 1'b0);
		end
	endtask

	initial begin : run_stimulus
		logic [RadixWidth-1:0] radix_plan [12];
		int made;
		int n;
		radix_plan = '{5'd0, 5'd16, 5'd1, 5'd31, 5'd10, 5'd2, 5'd0, 5'd8, 5'd13, 5'd17, 5'd0,
			5'($urandom_range(0, 31))};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		put(ChSpace, 1'b1);
		put(ChTab, 1'b0);
		put(ChLf, 1'b0);
		put(ChVt, 1'b0);
		put(ChFf, 1'b0);
		put(ChCr, 1'b0);
		put_text("+0x1aF g", 1'b0);
		put_text("-", 1'b1);
		put(ChNul, 1'b0);
		put_text("0xz", 1'b1);
		put_text("08", 1'b1);
		put_text("q7", 1'b0);
		put_text("7", 1'b1);
		settle();
		write_radix(BaseHex);
		put_text("a", 1'b0);
		put_text("-ff", 1'b1);
		put(ChNul, 1'b0);
		settle();

		foreach (radix_plan[p]) begin
			write_radix(radix_plan[p]);
			send_gapless = (p == 3 || p == 6);
			recv_gapless = (p == 6);
			squeeze_req = (p == 3);
			made = 0;
			while (made < 125) begin
				if ($urandom_range(0, 9) == 0) begin
					n = $urandom_range(1, 6);
					repeat (n) put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				end else begin
					add_number(n);
				end
				made += n;
			end
			settle();
		end
		write_radix(5'd31);
		put_text("99", 1'b1);
		put(ChNul, 1'b0);
		settle();

		$display("Checked %0d parsed integers over %0d radix settings, %0d characters taken.",
			ints_checked, radix_settings, chars_taken);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin : watchdog
		#8000000;
		$display("FAILURE");
		$finish;
	end

endmodule
